// File: sv/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg
// types and constants shared by the token scanner modules
// ----------------------------------------------------------------------------
package sts_pkg;

    localparam int KIND_W = 6;
    localparam int OUT_W  = 16;

    localparam logic [KIND_W-1:0] K_EOF      = 6'd0;
    localparam logic [KIND_W-1:0] K_IDENT    = 6'd1;
    localparam logic [KIND_W-1:0] K_INT      = 6'd21;
    localparam logic [KIND_W-1:0] K_STR      = 6'd22;
    localparam logic [KIND_W-1:0] K_PLUS     = 6'd23;
    localparam logic [KIND_W-1:0] K_MINUS    = 6'd24;
    localparam logic [KIND_W-1:0] K_STAR     = 6'd25;
    localparam logic [KIND_W-1:0] K_SLASH    = 6'd26;
    localparam logic [KIND_W-1:0] K_PERCENT  = 6'd27;
    localparam logic [KIND_W-1:0] K_COMMA    = 6'd28;
    localparam logic [KIND_W-1:0] K_LPAREN   = 6'd29;
    localparam logic [KIND_W-1:0] K_RPAREN   = 6'd30;
    localparam logic [KIND_W-1:0] K_SEMI     = 6'd31;
    localparam logic [KIND_W-1:0] K_EQ       = 6'd32;
    localparam logic [KIND_W-1:0] K_NE       = 6'd33;
    localparam logic [KIND_W-1:0] K_LT       = 6'd34;
    localparam logic [KIND_W-1:0] K_LE       = 6'd35;
    localparam logic [KIND_W-1:0] K_GT       = 6'd36;
    localparam logic [KIND_W-1:0] K_GE       = 6'd37;
    localparam logic [KIND_W-1:0] K_ERR_CHAR = 6'd38;
    localparam logic [KIND_W-1:0] K_ERR_BANG = 6'd39;
    localparam logic [KIND_W-1:0] K_ERR_STR  = 6'd40;

    localparam int NUM_KW = 19;

    // keyword text, right aligned, upper case
    localparam logic [47:0] KW_TEXT [NUM_KW] = '{
        48'h53454C454354, 48'h000046524F4D, 48'h005748455245, 48'h494E53455254,
        48'h0000494E544F, 48'h555044415445, 48'h000000534554, 48'h44454C455445,
        48'h435245415445, 48'h005441424C45, 48'h000044524F50, 48'h000054455854,
        48'h00004C4F4E47, 48'h00004C494B45, 48'h00000000494E, 48'h000000414E44,
        48'h000000004F52, 48'h0000004E4F54, 48'h000000414C4C
    };
    localparam logic [2:0] KW_LEN [NUM_KW] = '{
        3'd6, 3'd4, 3'd5, 3'd6, 3'd4, 3'd6, 3'd3, 3'd6, 3'd6, 3'd5,
        3'd4, 3'd4, 3'd4, 3'd4, 3'd2, 3'd3, 3'd2, 3'd3, 3'd3
    };

    // one token record
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [OUT_W-1:0]  line;
        logic [OUT_W-1:0]  column;
        logic [OUT_W-1:0]  offset;
        logic [OUT_W-1:0]  length;
        logic              run_end;
    } t_rec;

    // up to three records caused by one byte
    typedef struct packed {
        logic [1:0] count;
        t_rec       r0;
        t_rec       r1;
        t_rec       r2;
    } t_group;

endpackage

// File: sv/sts_front.sv
// ----------------------------------------------------------------------------
// sts_front
// per-byte scanner state machine, produces up to three records per byte
// ----------------------------------------------------------------------------
module sts_front
    import sts_pkg::*;
#(
    parameter int POSITION_WIDTH  = 16,
    parameter int KEYWORD_MAX_LEN = 6
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_char_code,
    input  logic       i_last,
    output logic       o_valid,
    output t_group     o_group
);

    localparam int PW  = POSITION_WIDTH;
    localparam int WBW = 8 * KEYWORD_MAX_LEN;
    localparam int WCW = $clog2(KEYWORD_MAX_LEN + 2);
    localparam logic [PW-1:0] PMAX = {PW{1'b1}};

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_NUMBER, M_MINUS, M_SLASH, M_LT, M_GT, M_BANG,
        M_STRING, M_LINE_CMT, M_BLOCK, M_BLOCK_STAR, M_ERROR
    } t_mode;

    t_mode           r_mode, n_mode;
    logic [PW-1:0]   r_line, n_line, r_col, n_col, r_off, n_off;
    logic [PW-1:0]   r_tline, n_tline, r_tcol, n_tcol, r_toff, n_toff, r_tlen, n_tlen;
    logic [WBW-1:0]  r_wbuf, n_wbuf;
    logic [WCW-1:0]  r_wcnt, n_wcnt;
    logic            r_valid;
    t_group          r_group, n_group;

    function automatic logic [PW-1:0] sat_inc(input logic [PW-1:0] v);
        sat_inc = (v == PMAX) ? v : v + 1'b1;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        is_alpha = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    logic [7:0]        c;
    logic [KIND_W-1:0] wkind;

    assign c = i_char_code;

    always_comb begin
        wkind = K_IDENT;
        if (r_wcnt <= WCW'(KEYWORD_MAX_LEN)) begin
            for (int k = NUM_KW - 1; k >= 0; k--) begin
                if ((WCW'(KW_LEN[k]) == r_wcnt) && (WBW'(KW_TEXT[k]) == r_wbuf)) begin
                    wkind = KIND_W'(2 + k);
                end
            end
        end
    end

    always_comb begin
        logic [KIND_W-1:0] kinds [3];
        logic [PW-1:0]     lines [3], cols [3], offs [3], lens [3];
        logic [1:0]        cnt;
        logic              idle_scan, fin;
        logic [KIND_W-1:0] pk;
        logic              have_pk;
        logic [7:0]        up;

        n_mode = r_mode; n_line = r_line; n_col = r_col; n_off = r_off;
        n_tline = r_tline; n_tcol = r_tcol; n_toff = r_toff; n_tlen = r_tlen;
        n_wbuf = r_wbuf; n_wcnt = r_wcnt;
        for (int k = 0; k < 3; k++) begin
            kinds[k] = K_EOF; lines[k] = '0; cols[k] = '0; offs[k] = '0; lens[k] = '0;
        end
        cnt = 2'd0;
        idle_scan = 1'b0;
        pk = K_EOF;
        have_pk = 1'b0;
        fin = (c == 8'd0) || i_last;
        up = ((c >= 8'h61) && (c <= 8'h7A)) ? c - 8'd32 : c;

        if (c != 8'd0) begin
            case (r_mode)
                M_IDLE: idle_scan = 1'b1;
                M_IDENT: begin
                    if (is_alpha(c) || is_digit(c) || c == 8'h5F) begin
                        if (r_wcnt < WCW'(KEYWORD_MAX_LEN)) begin
                            n_wbuf = {r_wbuf[WBW-9:0], up};
                            n_wcnt = r_wcnt + 1'b1;
                        end else begin
                            n_wcnt = WCW'(KEYWORD_MAX_LEN + 1);
                        end
                        n_tlen = sat_inc(r_tlen);
                    end else begin
                        kinds[cnt] = wkind; cnt = cnt + 1'b1; idle_scan = 1'b1;
                    end
                end
                M_NUMBER: begin
                    if (is_digit(c)) n_tlen = sat_inc(r_tlen);
                    else begin kinds[cnt] = K_INT; cnt = cnt + 1'b1; idle_scan = 1'b1; end
                end
                M_MINUS: begin
                    if (c == 8'h2D) n_mode = M_LINE_CMT;
                    else if (is_digit(c)) begin
                        n_mode = M_NUMBER; n_tlen = sat_inc(r_tlen);
                    end else begin
                        kinds[cnt] = K_MINUS; cnt = cnt + 1'b1; idle_scan = 1'b1;
                    end
                end
                M_SLASH: begin
                    if (c == 8'h2A) n_mode = M_BLOCK;
                    else begin kinds[cnt] = K_SLASH; cnt = cnt + 1'b1; idle_scan = 1'b1; end
                end
                M_LT, M_GT: begin
                    if (c == 8'h3D) begin
                        n_tlen = sat_inc(r_tlen);
                        kinds[cnt] = (r_mode == M_LT) ? K_LE : K_GE;
                        lens[cnt] = n_tlen; cnt = cnt + 1'b1;
                        n_mode = M_IDLE;
                    end else begin
                        kinds[cnt] = (r_mode == M_LT) ? K_LT : K_GT;
                        cnt = cnt + 1'b1; idle_scan = 1'b1;
                    end
                end
                M_BANG: begin
                    if (c == 8'h3D) begin
                        n_tlen = sat_inc(r_tlen);
                        kinds[cnt] = K_NE; lens[cnt] = n_tlen; cnt = cnt + 1'b1;
                        n_mode = M_IDLE;
                    end else begin
                        kinds[cnt] = K_ERR_BANG; cnt = cnt + 1'b1; n_mode = M_ERROR;
                    end
                end
                M_STRING: begin
                    n_tlen = sat_inc(r_tlen);
                    if (c == 8'h27) begin
                        kinds[cnt] = K_STR; lens[cnt] = n_tlen; cnt = cnt + 1'b1;
                        n_mode = M_IDLE;
                    end
                end
                M_LINE_CMT: if (c == 8'h0A) n_mode = M_IDLE;
                M_BLOCK:    if (c == 8'h2A) n_mode = M_BLOCK_STAR;
                M_BLOCK_STAR: begin
                    if (c == 8'h2F) n_mode = M_IDLE;
                    else if (c != 8'h2A) n_mode = M_BLOCK;
                end
                M_ERROR: ;
                default: idle_scan = 1'b1;
            endcase
            // pending records use the registered token start
            for (int k = 0; k < 3; k++) begin
                if (k < cnt) begin
                    lines[k] = r_tline; cols[k] = r_tcol; offs[k] = r_toff;
                    if (lens[k] == '0) lens[k] = r_tlen;
                end
            end

            if (idle_scan) begin
                n_mode = M_IDLE;
                if (!((c == 8'h20) || ((c >= 8'd9) && (c <= 8'd13)))) begin
                    n_tline = r_line; n_tcol = r_col; n_toff = r_off;
                    n_tlen = PW'(1);
                    have_pk = 1'b0;
                    pk = K_EOF;
                    if (is_alpha(c)) begin
                        n_wbuf = WBW'(up); n_wcnt = WCW'(1); n_mode = M_IDENT;
                    end else if (is_digit(c)) n_mode = M_NUMBER;
                    else begin
                        case (c)
                            8'h2D: n_mode = M_MINUS;
                            8'h2F: n_mode = M_SLASH;
                            8'h3C: n_mode = M_LT;
                            8'h3E: n_mode = M_GT;
                            8'h21: n_mode = M_BANG;
                            8'h27: n_mode = M_STRING;
                            8'h2B: begin pk = K_PLUS;    have_pk = 1'b1; end
                            8'h2A: begin pk = K_STAR;    have_pk = 1'b1; end
                            8'h25: begin pk = K_PERCENT; have_pk = 1'b1; end
                            8'h2C: begin pk = K_COMMA;   have_pk = 1'b1; end
                            8'h28: begin pk = K_LPAREN;  have_pk = 1'b1; end
                            8'h29: begin pk = K_RPAREN;  have_pk = 1'b1; end
                            8'h3B: begin pk = K_SEMI;    have_pk = 1'b1; end
                            8'h3D: begin pk = K_EQ;      have_pk = 1'b1; end
                            default: begin
                                pk = K_ERR_CHAR; have_pk = 1'b1; n_mode = M_ERROR;
                            end
                        endcase
                    end
                    if (have_pk) begin
                        kinds[cnt] = pk; lines[cnt] = r_line; cols[cnt] = r_col;
                        offs[cnt] = r_off; lens[cnt] = PW'(1); cnt = cnt + 1'b1;
                    end
                end
            end
            // every consumed nonzero byte advances the position
            if (c == 8'h0A) begin
                n_line = sat_inc(r_line); n_col = PW'(1);
            end else begin
                n_col = sat_inc(r_col);
            end
            n_off = sat_inc(r_off);
        end

        if (fin) begin
            have_pk = 1'b1;
            case (n_mode)
                M_IDENT:  pk = (c == 8'd0) ? wkind : K_IDENT;
                M_NUMBER: pk = K_INT;
                M_MINUS:  pk = K_MINUS;
                M_SLASH:  pk = K_SLASH;
                M_LT:     pk = K_LT;
                M_GT:     pk = K_GT;
                M_BANG:   pk = K_ERR_BANG;
                M_STRING: pk = K_ERR_STR;
                default:  begin pk = K_EOF; have_pk = 1'b0; end
            endcase
            if (n_mode == M_IDENT && c != 8'd0) begin
                pk = K_IDENT;
                if (n_wcnt <= WCW'(KEYWORD_MAX_LEN)) begin
                    for (int k = NUM_KW - 1; k >= 0; k--) begin
                        if ((WCW'(KW_LEN[k]) == n_wcnt) && (WBW'(KW_TEXT[k]) == n_wbuf))
                            pk = KIND_W'(2 + k);
                    end
                end
            end
            if (have_pk) begin
                kinds[cnt] = pk; lines[cnt] = n_tline; cols[cnt] = n_tcol;
                offs[cnt] = n_toff; lens[cnt] = n_tlen; cnt = cnt + 1'b1;
            end
            kinds[cnt] = K_EOF; lines[cnt] = n_line; cols[cnt] = n_col;
            offs[cnt] = n_off; lens[cnt] = '0; cnt = cnt + 1'b1;
            n_mode = M_IDLE; n_line = PW'(1); n_col = PW'(1); n_off = '0;
            n_tline = '0; n_tcol = '0; n_toff = '0; n_tlen = '0;
            n_wbuf = '0; n_wcnt = '0;
        end

        n_group.count = cnt;
        n_group.r0 = '{kinds[0], OUT_W'(lines[0]), OUT_W'(cols[0]), OUT_W'(offs[0]),
                       OUT_W'(lens[0]), cnt == 2'd1};
        n_group.r1 = '{kinds[1], OUT_W'(lines[1]), OUT_W'(cols[1]), OUT_W'(offs[1]),
                       OUT_W'(lens[1]), cnt == 2'd2};
        n_group.r2 = '{kinds[2], OUT_W'(lines[2]), OUT_W'(cols[2]), OUT_W'(offs[2]),
                       OUT_W'(lens[2]), cnt == 2'd3};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_line <= PW'(1); r_col <= PW'(1); r_off <= '0;
            r_tline <= '0; r_tcol <= '0; r_toff <= '0; r_tlen <= '0;
            r_wbuf <= '0; r_wcnt <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (i_valid) begin
                r_mode <= n_mode;
                r_line <= n_line; r_col <= n_col; r_off <= n_off;
                r_tline <= n_tline; r_tcol <= n_tcol; r_toff <= n_toff; r_tlen <= n_tlen;
                r_wbuf <= n_wbuf; r_wcnt <= n_wcnt;
                r_valid <= (n_group.count != 2'd0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_group <= n_group;
        end
    end

    assign o_valid = r_valid;
    assign o_group = r_group;

endmodule

// File: sv/sts_back.sv
// ----------------------------------------------------------------------------
// sts_back
// record group queue and serialiser onto the result port
// ----------------------------------------------------------------------------
module sts_back
    import sts_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_group i_group,
    output logic   o_afull,
    output logic   o_empty,
    input  logic   i_pop,
    output t_rec   o_rec
);

    localparam int AW = $clog2(DEPTH);

    t_group          r_mem [DEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [AW:0]     r_cnt;
    logic [1:0]      r_sub;
    t_group          head;
    logic            done;

    assign head    = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    // headroom for the group in flight in the front stage
    assign o_afull = (r_cnt >= (AW+1)'(DEPTH - 2));
    assign done    = i_pop && !o_empty && ((r_sub + 1'b1) == head.count);

    always_comb begin
        case (r_sub)
            2'd0:    o_rec = head.r0;
            2'd1:    o_rec = head.r1;
            default: o_rec = head.r2;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_group;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0; r_sub <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (done) begin
                r_rp <= r_rp + 1'b1;
                r_sub <= '0;
            end else if (i_pop && !o_empty) begin
                r_sub <= r_sub + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(done);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt < (AW+1)'(DEPTH) || done)) else $error("queue overflow");
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> head.count != 2'd0) else $error("empty group queued");
    a_sub_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> r_sub < head.count) else $error("record index out of range");

endmodule

// File: sv/sql_token_scanner.sv
// ----------------------------------------------------------------------------
// sql_token_scanner
// SQL lexer: one source byte per transfer in, token records out
// ----------------------------------------------------------------------------
// Input channel: push/full carries i_char_code and i_last; one byte per
// cycle is taken while full is low. A zero byte or a byte with last set ends
// the statement and adds an EOF record after any pending token.
// Result channel: empty/pop; the oldest record sits on the o_ ports while
// empty is low. o_run_end marks the last record caused by one byte.
// Path: a byte's record group is registered in the front stage, then queued,
// and the queue head drives the result ports. Throughput: one byte per cycle
// while full is low; one record is popped per cycle, so a byte causing up to
// three records holds the queue head for that many pops.
// Stall: when the receiver stops popping, the group queue fills and full
// rises; the scanner state machine holds until space returns.
// Reset: synchronous; position returns to line 1, column 1, offset 0 and the
// queue empties.
// ----------------------------------------------------------------------------
module sql_token_scanner
    import sts_pkg::*;
#(
    parameter int POSITION_WIDTH  = 16,
    parameter int KEYWORD_MAX_LEN = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_char_code,
    input  logic        i_last,
    output logic        empty,
    input  logic        pop,
    output logic [5:0]  o_token_kind,
    output logic [15:0] o_start_line,
    output logic [15:0] o_start_column,
    output logic [15:0] o_start_offset,
    output logic [15:0] o_token_length,
    output logic        o_run_end
);

    logic   f_valid;
    t_group f_group;
    t_rec   rec;
    logic   afull;

    assign full = afull;

    sts_front #(
        .POSITION_WIDTH  (POSITION_WIDTH),
        .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (push && !afull),
        .i_char_code (i_char_code),
        .i_last      (i_last),
        .o_valid     (f_valid),
        .o_group     (f_group)
    );

    sts_back #(
        .DEPTH (4)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_group (f_group),
        .o_afull (afull),
        .o_empty (empty),
        .i_pop   (pop),
        .o_rec   (rec)
    );

    assign o_token_kind   = rec.kind;
    assign o_start_line   = rec.line;
    assign o_start_column = rec.column;
    assign o_start_offset = rec.offset;
    assign o_token_length = rec.length;
    assign o_run_end      = rec.run_end;

endmodule
